// File: rtl/mlsn_pkg.sv
// shared types, codes, rate table and speed selection for the link speed negotiator
`default_nettype none

package mlsn_pkg;

    // widths of the beat fields and registers
    localparam int unsigned OP_W      = 2;
    localparam int unsigned KIND_W    = 3;
    localparam int unsigned PEER_W    = 14;
    localparam int unsigned LOCAL_W   = 11;
    localparam int unsigned TICK_W    = 16;
    localparam int unsigned SEND_W    = 3;
    localparam int unsigned IDX_W     = 4;
    localparam int unsigned RATE_W    = 20;
    localparam int unsigned PHASE_W   = 3;
    localparam int unsigned DATA_W    = 32;
    localparam int unsigned ADDR_W    = 4;
    localparam int unsigned REG_SEL_W = 2;

    localparam logic [TICK_W-1:0] TIMEOUT_RESET = 16'd1000;
    localparam logic [TICK_W-1:0] TICK_MAX      = 16'hFFFF;

    // operation codes of an input beat
    typedef enum logic [OP_W-1:0] {
        OP_START = 2'd0,
        OP_MSG   = 2'd1,
        OP_TICK  = 2'd2,
        OP_STOP  = 2'd3
    } op_t;

    // received message kinds
    localparam logic [KIND_W-1:0] MSG_SPEED_ANSWER = 3'd0;
    localparam logic [KIND_W-1:0] MSG_NEG_ACK      = 3'd1;
    localparam logic [KIND_W-1:0] MSG_TEST1_RESULT = 3'd2;
    localparam logic [KIND_W-1:0] MSG_TEST2_RESULT = 3'd3;

    // message kinds sent by the master
    localparam logic [SEND_W-1:0] SEND_NONE      = 3'd0;
    localparam logic [SEND_W-1:0] SEND_SPEED_REQ = 3'd1;
    localparam logic [SEND_W-1:0] SEND_NEGOTIATE = 3'd2;
    localparam logic [SEND_W-1:0] SEND_TEST1     = 3'd3;
    localparam logic [SEND_W-1:0] SEND_TEST2     = 3'd4;

    // phase codes as seen on the result beat
    localparam logic [PHASE_W-1:0] PHASE_NORMAL     = 3'd0;
    localparam logic [PHASE_W-1:0] PHASE_WAIT_ANSW  = 3'd1;
    localparam logic [PHASE_W-1:0] PHASE_WAIT_ACK   = 3'd2;
    localparam logic [PHASE_W-1:0] PHASE_WAIT_TEST1 = 3'd3;
    localparam logic [PHASE_W-1:0] PHASE_WAIT_TEST2 = 3'd4;
    localparam logic [PHASE_W-1:0] PHASE_OK         = 3'd5;

    // register select from paddr[3:2]
    localparam logic [REG_SEL_W-1:0] REG_LOCAL_SPEEDS = 2'd0;
    localparam logic [REG_SEL_W-1:0] REG_LOCAL_CERT   = 2'd1;
    localparam logic [REG_SEL_W-1:0] REG_TIMEOUT      = 2'd2;

    // negotiation state machine, one-hot
    typedef enum logic [5:0] {
        ST_NORMAL     = 6'b000001,
        ST_WAIT_ANSW  = 6'b000010,
        ST_WAIT_ACK   = 6'b000100,
        ST_WAIT_TEST1 = 6'b001000,
        ST_WAIT_TEST2 = 6'b010000,
        ST_OK         = 6'b100000
    } phase_t;

    localparam logic [IDX_W-1:0] RATE_LAST_IDX = 4'd11;

    // baud rate per speed index, indexes past the table take the last entry
    function automatic logic [RATE_W-1:0] rate_of(input logic [IDX_W-1:0] idx);
        logic [RATE_W-1:0] rate;
        unique case (idx)
            4'd0:    rate = 20'd31250;
            4'd1:    rate = 20'd31250;
            4'd2:    rate = 20'd62500;
            4'd3:    rate = 20'd104062;
            4'd4:    rate = 20'd125000;
            4'd5:    rate = 20'd156250;
            4'd6:    rate = 20'd208125;
            4'd7:    rate = 20'd250000;
            4'd8:    rate = 20'd312500;
            4'd9:    rate = 20'd415625;
            4'd10:   rate = 20'd500000;
            default: rate = 20'd625000;
        endcase
        return rate;
    endfunction

    // highest common bit plus one, saturated at the last usable index
    function automatic logic [IDX_W-1:0] pick_speed(input logic [LOCAL_W-1:0] common,
                                                   input logic [IDX_W-1:0]   max_idx);
        logic [IDX_W-1:0] top;
        logic [IDX_W-1:0] idx;
        top = '0;
        for (int i = 0; i < LOCAL_W; i++) begin
            if (common[i])
            begin
                top = IDX_W'(i);
            end
        end
        idx = top + 4'd1;
        if (idx > max_idx)
        begin
            idx = max_idx;
        end
        return idx;
    endfunction

    // state to result phase code
    function automatic logic [PHASE_W-1:0] phase_code(input phase_t st);
        logic [PHASE_W-1:0] code;
        unique case (st)
            ST_NORMAL:     code = PHASE_NORMAL;
            ST_WAIT_ANSW:  code = PHASE_WAIT_ANSW;
            ST_WAIT_ACK:   code = PHASE_WAIT_ACK;
            ST_WAIT_TEST1: code = PHASE_WAIT_TEST1;
            ST_WAIT_TEST2: code = PHASE_WAIT_TEST2;
            ST_OK:         code = PHASE_OK;
            default:       code = PHASE_NORMAL;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

// File: rtl/midi_link_speed_negotiator.sv
// link speed negotiation master: input register, one step of logic, result register
//
//  channel  | handshake          | beat fields
//  ---------+--------------------+---------------------------------------------------
//  in       | in_valid/in_stall  | op, msg_kind, peer_speeds, peer_certified_speeds
//  out      | out_valid/out_stall| send_kind, chosen_first, chosen_second,
//           |                    | active_speed, bit_rate, phase, finished, succeeded
//  config   | APB psel/penable   | paddr 0 local_speeds, 4 certified, 8 timeout_ticks
//
//  one beat per cycle sustained while out_stall is low; a taken beat passes the input register,
//  then the result register, with the negotiation state updated alongside
//  reset puts the link in the normal phase at index 0, timeout_ticks at 1000
//  a stalled result holds; the input register still takes a beat while the result waits
//  in_stall rises only when the input register is full and the full result is stalled
`default_nettype none

module midi_link_speed_negotiator #(
    parameter int unsigned SPEED_COUNT = 12
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // input channel
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [mlsn_pkg::OP_W-1:0]         op,
    input  wire logic [mlsn_pkg::KIND_W-1:0]       msg_kind,
    input  wire logic [mlsn_pkg::PEER_W-1:0]       peer_speeds,
    input  wire logic [mlsn_pkg::PEER_W-1:0]       peer_certified_speeds,
    // output channel
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic [mlsn_pkg::SEND_W-1:0]            send_kind,
    output logic [mlsn_pkg::IDX_W-1:0]             chosen_first,
    output logic [mlsn_pkg::IDX_W-1:0]             chosen_second,
    output logic [mlsn_pkg::IDX_W-1:0]             active_speed,
    output logic [mlsn_pkg::RATE_W-1:0]            bit_rate,
    output logic [mlsn_pkg::PHASE_W-1:0]           phase,
    output logic                                   finished,
    output logic                                   succeeded,
    // configuration port
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [mlsn_pkg::ADDR_W-1:0]       paddr,
    input  wire logic [mlsn_pkg::DATA_W-1:0]       pwdata,
    output logic [mlsn_pkg::DATA_W-1:0]            prdata,
    output logic                                   pready
);

    localparam logic [mlsn_pkg::IDX_W-1:0] MAX_IDX = mlsn_pkg::IDX_W'(SPEED_COUNT - 1);

    // configuration registers
    logic [mlsn_pkg::LOCAL_W-1:0] local_speeds_reg;
    logic [mlsn_pkg::LOCAL_W-1:0] local_cert_reg;
    logic [mlsn_pkg::TICK_W-1:0]  timeout_reg;
    logic                         cfg_write;
    logic [mlsn_pkg::REG_SEL_W-1:0] reg_sel;

    // input register
    logic                         in_vld_reg;
    mlsn_pkg::op_t                op_reg;
    logic [mlsn_pkg::KIND_W-1:0]  kind_reg;
    logic [mlsn_pkg::LOCAL_W-1:0] peer_reg;
    logic [mlsn_pkg::LOCAL_W-1:0] peer_cert_reg;

    // negotiation state
    mlsn_pkg::phase_t             phase_reg;
    mlsn_pkg::phase_t             phase_next;
    logic [mlsn_pkg::TICK_W-1:0]  wait_cnt_reg;
    logic [mlsn_pkg::TICK_W-1:0]  wait_cnt_next;
    logic [mlsn_pkg::TICK_W-1:0]  wait_cnt_inc;
    logic [mlsn_pkg::IDX_W-1:0]   speed_reg;
    logic [mlsn_pkg::IDX_W-1:0]   speed_next;
    logic [mlsn_pkg::IDX_W-1:0]   first_reg;
    logic [mlsn_pkg::IDX_W-1:0]   first_next;
    logic [mlsn_pkg::IDX_W-1:0]   second_reg;
    logic [mlsn_pkg::IDX_W-1:0]   second_next;
    logic [mlsn_pkg::SEND_W-1:0]  send_next;
    logic                         fin_next;
    logic                         ok_next;
    logic                         in_wait;

    // result register
    logic                         out_vld_reg;
    logic [mlsn_pkg::SEND_W-1:0]  send_reg;
    logic [mlsn_pkg::IDX_W-1:0]   chosen_first_reg;
    logic [mlsn_pkg::IDX_W-1:0]   chosen_second_reg;
    logic [mlsn_pkg::IDX_W-1:0]   active_reg;
    logic [mlsn_pkg::RATE_W-1:0]  rate_reg;
    logic [mlsn_pkg::PHASE_W-1:0] phase_out_reg;
    logic                         fin_reg;
    logic                         ok_reg;

    logic                         advance;
    logic                         in_take;

    // handshake between the two stages
    assign advance  = in_vld_reg && (!out_vld_reg || !out_stall);
    assign in_stall = in_vld_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    // configuration port
    assign pready    = 1'b1;
    assign reg_sel   = paddr[mlsn_pkg::ADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        unique case (reg_sel)
            mlsn_pkg::REG_LOCAL_SPEEDS: prdata = mlsn_pkg::DATA_W'(local_speeds_reg);
            mlsn_pkg::REG_LOCAL_CERT:   prdata = mlsn_pkg::DATA_W'(local_cert_reg);
            mlsn_pkg::REG_TIMEOUT:      prdata = mlsn_pkg::DATA_W'(timeout_reg);
            default:                    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            local_speeds_reg <= '0;
            local_cert_reg   <= '0;
            timeout_reg      <= mlsn_pkg::TIMEOUT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (reg_sel)
                mlsn_pkg::REG_LOCAL_SPEEDS: local_speeds_reg <= pwdata[mlsn_pkg::LOCAL_W-1:0];
                mlsn_pkg::REG_LOCAL_CERT:   local_cert_reg   <= pwdata[mlsn_pkg::LOCAL_W-1:0];
                mlsn_pkg::REG_TIMEOUT:      timeout_reg      <= pwdata[mlsn_pkg::TICK_W-1:0];
                default:                    ;
            endcase
        end
    end

    // input register, valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_vld_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_vld_reg <= 1'b0;
        end
    end

    // input register, payload
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            op_reg        <= mlsn_pkg::op_t'(op);
            kind_reg      <= msg_kind;
            peer_reg      <= peer_speeds[mlsn_pkg::LOCAL_W-1:0];
            peer_cert_reg <= peer_certified_speeds[mlsn_pkg::LOCAL_W-1:0];
        end
    end

    // saturating tick count
    assign wait_cnt_inc = (wait_cnt_reg == mlsn_pkg::TICK_MAX) ? wait_cnt_reg
                                                               : wait_cnt_reg + 16'd1;
    assign in_wait = (phase_reg == mlsn_pkg::ST_WAIT_ANSW)  ||
                     (phase_reg == mlsn_pkg::ST_WAIT_ACK)   ||
                     (phase_reg == mlsn_pkg::ST_WAIT_TEST1) ||
                     (phase_reg == mlsn_pkg::ST_WAIT_TEST2);

    // one negotiation step for the beat in the input register
    always_comb
    begin
        phase_next    = phase_reg;
        wait_cnt_next = wait_cnt_reg;
        speed_next    = speed_reg;
        first_next    = first_reg;
        second_next   = second_reg;
        send_next     = mlsn_pkg::SEND_NONE;
        fin_next      = 1'b0;
        ok_next       = 1'b0;
        unique case (op_reg)
            mlsn_pkg::OP_START:
            begin
                first_next    = '0;
                second_next   = '0;
                speed_next    = '0;
                wait_cnt_next = '0;
                phase_next    = mlsn_pkg::ST_WAIT_ANSW;
                send_next     = mlsn_pkg::SEND_SPEED_REQ;
            end
            mlsn_pkg::OP_MSG:
            begin
                priority if (phase_reg == mlsn_pkg::ST_WAIT_ANSW &&
                             kind_reg == mlsn_pkg::MSG_SPEED_ANSWER)
                begin
                    first_next    = mlsn_pkg::pick_speed(local_speeds_reg & peer_reg, MAX_IDX);
                    second_next   = mlsn_pkg::pick_speed(local_cert_reg & peer_cert_reg,
                                                         MAX_IDX);
                    wait_cnt_next = '0;
                    phase_next    = mlsn_pkg::ST_WAIT_ACK;
                    send_next     = mlsn_pkg::SEND_NEGOTIATE;
                end
                else if (phase_reg == mlsn_pkg::ST_WAIT_ACK &&
                         kind_reg == mlsn_pkg::MSG_NEG_ACK)
                begin
                    speed_next    = first_reg;
                    wait_cnt_next = '0;
                    phase_next    = mlsn_pkg::ST_WAIT_TEST1;
                    send_next     = mlsn_pkg::SEND_TEST1;
                end
                else if (phase_reg == mlsn_pkg::ST_WAIT_TEST1 &&
                         kind_reg == mlsn_pkg::MSG_TEST1_RESULT)
                begin
                    speed_next    = second_reg;
                    wait_cnt_next = '0;
                    phase_next    = mlsn_pkg::ST_WAIT_TEST2;
                    send_next     = mlsn_pkg::SEND_TEST2;
                end
                else if (phase_reg == mlsn_pkg::ST_WAIT_TEST2 &&
                         kind_reg == mlsn_pkg::MSG_TEST2_RESULT)
                begin
                    wait_cnt_next = '0;
                    phase_next    = mlsn_pkg::ST_OK;
                    fin_next      = 1'b1;
                    ok_next       = 1'b1;
                end
                else
                begin
                    // wrong phase or unknown kind: nothing happens
                    send_next = mlsn_pkg::SEND_NONE;
                end
            end
            mlsn_pkg::OP_TICK:
            begin
                if (in_wait)
                begin
                    wait_cnt_next = wait_cnt_inc;
                    if (wait_cnt_inc >= timeout_reg)
                    begin
                        speed_next    = '0;
                        phase_next    = mlsn_pkg::ST_NORMAL;
                        wait_cnt_next = '0;
                        fin_next      = 1'b1;
                    end
                end
            end
            mlsn_pkg::OP_STOP:
            begin
                speed_next    = '0;
                phase_next    = mlsn_pkg::ST_NORMAL;
                wait_cnt_next = '0;
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase
    end

    // negotiation state, moves with each beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= mlsn_pkg::ST_NORMAL;
            wait_cnt_reg <= '0;
            speed_reg    <= '0;
            first_reg    <= '0;
            second_reg   <= '0;
        end
        else if (advance)
        begin
            phase_reg    <= phase_next;
            wait_cnt_reg <= wait_cnt_next;
            speed_reg    <= speed_next;
            first_reg    <= first_next;
            second_reg   <= second_next;
        end
    end

    // result register, valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    // result register, payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            send_reg          <= send_next;
            chosen_first_reg  <= first_next;
            chosen_second_reg <= second_next;
            active_reg        <= speed_next;
            rate_reg          <= mlsn_pkg::rate_of(speed_next);
            phase_out_reg     <= mlsn_pkg::phase_code(phase_next);
            fin_reg           <= fin_next;
            ok_reg            <= ok_next;
        end
    end

    assign out_valid     = out_vld_reg;
    assign send_kind     = send_reg;
    assign chosen_first  = chosen_first_reg;
    assign chosen_second = chosen_second_reg;
    assign active_speed  = active_reg;
    assign bit_rate      = rate_reg;
    assign phase         = phase_out_reg;
    assign finished      = fin_reg;
    assign succeeded     = ok_reg;

    // success only ends the exchange in the ok phase
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && succeeded |-> finished && (phase == mlsn_pkg::PHASE_OK))
    else $error("success reported outside the ok phase");

    // a beat that sends a message never ends the exchange
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (send_kind != mlsn_pkg::SEND_NONE) |-> !finished)
    else $error("message sent on an ending beat");

    // normal phase always runs at index zero
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (phase == mlsn_pkg::PHASE_NORMAL) |-> (active_speed == '0))
    else $error("normal phase with a raised speed index");

    // a beat held in the input register is not lost
    assert property (@(posedge clk) disable iff (!rst_n)
        in_vld_reg && !advance |=> in_vld_reg)
    else $error("input beat dropped while stalled");

    // the speed index only changes when a beat moves through
    assert property (@(posedge clk) disable iff (!rst_n)
        !$past(advance) |-> $stable(speed_reg))
    else $error("speed index changed without a beat");

endmodule

`default_nettype wire

// File: bench/tb.sv
// testbench for the link speed negotiation master: directed and random beats against a predictor
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned LAST_SPEED  = 11;
    localparam int unsigned CYCLE_LIMIT = 50_000;
    localparam int unsigned IDLE_PCT    = 37;
    localparam int unsigned HOLD_CYCLES = 90;
    localparam int unsigned SESSIONS    = 26;

    // message kinds the master does not know
    localparam logic [mlsn_pkg::KIND_W-1:0] MSG_OTHER    = 3'd4;
    localparam logic [mlsn_pkg::KIND_W-1:0] MSG_TOP_CODE = 3'd7;

    localparam int unsigned BAUD_TABLE [12] = '{
        31250, 31250, 62500, 104062, 125000, 156250,
        208125, 250000, 312500, 415625, 500000, 625000
    };

    typedef struct {
        mlsn_pkg::op_t                op;
        logic [mlsn_pkg::KIND_W-1:0]  kind;
        logic [mlsn_pkg::PEER_W-1:0]  peer;
        logic [mlsn_pkg::PEER_W-1:0]  peer_cert;
    } link_command_t;

    typedef struct packed {
        logic [mlsn_pkg::SEND_W-1:0]  send_kind;
        logic [mlsn_pkg::IDX_W-1:0]   chosen_first;
        logic [mlsn_pkg::IDX_W-1:0]   chosen_second;
        logic [mlsn_pkg::IDX_W-1:0]   active_speed;
        logic [mlsn_pkg::RATE_W-1:0]  bit_rate;
        logic [mlsn_pkg::PHASE_W-1:0] phase;
        logic                         finished;
        logic                         succeeded;
    } link_status_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                          in_valid = 1'b0;
    logic                          in_stall;
    logic [mlsn_pkg::OP_W-1:0]     op = '0;
    logic [mlsn_pkg::KIND_W-1:0]   msg_kind = '0;
    logic [mlsn_pkg::PEER_W-1:0]   peer_speeds = '0;
    logic [mlsn_pkg::PEER_W-1:0]   peer_certified_speeds = '0;

    logic                          out_valid;
    logic                          out_stall = 1'b0;
    logic [mlsn_pkg::SEND_W-1:0]   send_kind;
    logic [mlsn_pkg::IDX_W-1:0]    chosen_first;
    logic [mlsn_pkg::IDX_W-1:0]    chosen_second;
    logic [mlsn_pkg::IDX_W-1:0]    active_speed;
    logic [mlsn_pkg::RATE_W-1:0]   bit_rate;
    logic [mlsn_pkg::PHASE_W-1:0]  phase;
    logic                          finished;
    logic                          succeeded;

    logic                          psel = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite = 1'b0;
    logic [mlsn_pkg::ADDR_W-1:0]   paddr = '0;
    logic [mlsn_pkg::DATA_W-1:0]   pwdata = '0;
    logic [mlsn_pkg::DATA_W-1:0]   prdata;
    logic                          pready;

    // stimulus and expectations
    link_command_t queued_commands [$];
    link_status_t  predicted_status [$];
    bit            beat_taken = 1'b0;
    bit            steady = 1'b0;
    int unsigned   holds_asked = 0;
    int unsigned   holds_done = 0;
    int unsigned   hold_left = 0;
    int unsigned   mismatch_count = 0;
    int unsigned   cycle_count = 0;

    // predictor copy of the registers and negotiation state
    logic [mlsn_pkg::LOCAL_W-1:0] cfg_speeds = '0;
    logic [mlsn_pkg::LOCAL_W-1:0] cfg_certified = '0;
    logic [mlsn_pkg::TICK_W-1:0]  cfg_timeout = 16'd1000;
    logic [mlsn_pkg::PHASE_W-1:0] link_phase = mlsn_pkg::PHASE_NORMAL;
    logic [mlsn_pkg::TICK_W-1:0]  tick_count = '0;
    logic [mlsn_pkg::IDX_W-1:0]   link_index = '0;
    logic [mlsn_pkg::IDX_W-1:0]   first_pick = '0;
    logic [mlsn_pkg::IDX_W-1:0]   second_pick = '0;
    logic [mlsn_pkg::PEER_W-1:0]  peer_mask = '0;
    logic [mlsn_pkg::PEER_W-1:0]  peer_cert_mask = '0;

    midi_link_speed_negotiator DUT (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .in_valid              (in_valid),
        .in_stall              (in_stall),
        .op                    (op),
        .msg_kind              (msg_kind),
        .peer_speeds           (peer_speeds),
        .peer_certified_speeds (peer_certified_speeds),
        .out_valid             (out_valid),
        .out_stall             (out_stall),
        .send_kind             (send_kind),
        .chosen_first          (chosen_first),
        .chosen_second         (chosen_second),
        .active_speed          (active_speed),
        .bit_rate              (bit_rate),
        .phase                 (phase),
        .finished              (finished),
        .succeeded             (succeeded),
        .psel                  (psel),
        .penable               (penable),
        .pwrite                (pwrite),
        .paddr                 (paddr),
        .pwdata                (pwdata),
        .prdata                (prdata),
        .pready                (pready)
    );

    // clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // highest bit shared by both masks plus one, clipped to the last speed
    function automatic logic [mlsn_pkg::IDX_W-1:0] shared_speed(
        input logic [mlsn_pkg::PEER_W-1:0] common);
        int top;
        top = 0;
        for (int i = 0; i < mlsn_pkg::PEER_W; i++)
        begin
            if (common[i])
            begin
                top = i;
            end
        end
        return mlsn_pkg::IDX_W'((top + 1 > LAST_SPEED) ? LAST_SPEED : top + 1);
    endfunction

    function automatic logic [mlsn_pkg::RATE_W-1:0] baud_for(
        input logic [mlsn_pkg::IDX_W-1:0] idx);
        return mlsn_pkg::RATE_W'(BAUD_TABLE[(idx > LAST_SPEED) ? LAST_SPEED : idx]);
    endfunction

    // one step of the negotiation, pushes the status beat it should produce
    task automatic advance_negotiation(input link_command_t c);
        link_status_t s;
        s = '0;
        s.send_kind = mlsn_pkg::SEND_NONE;
        unique case (c.op)
            mlsn_pkg::OP_START:
            begin
                peer_mask = '0;
                peer_cert_mask = '0;
                first_pick = '0;
                second_pick = '0;
                link_index = '0;
                tick_count = '0;
                link_phase = mlsn_pkg::PHASE_WAIT_ANSW;
                s.send_kind = mlsn_pkg::SEND_SPEED_REQ;
            end
            mlsn_pkg::OP_MSG:
            begin
                if (link_phase == mlsn_pkg::PHASE_WAIT_ANSW &&
                    c.kind == mlsn_pkg::MSG_SPEED_ANSWER)
                begin
                    peer_mask = c.peer;
                    peer_cert_mask = c.peer_cert;
                    first_pick = shared_speed(mlsn_pkg::PEER_W'(cfg_speeds) & peer_mask);
                    second_pick = shared_speed(mlsn_pkg::PEER_W'(cfg_certified) &
                                               peer_cert_mask);
                    tick_count = '0;
                    link_phase = mlsn_pkg::PHASE_WAIT_ACK;
                    s.send_kind = mlsn_pkg::SEND_NEGOTIATE;
                end
                else if (link_phase == mlsn_pkg::PHASE_WAIT_ACK &&
                         c.kind == mlsn_pkg::MSG_NEG_ACK)
                begin
                    link_index = first_pick;
                    tick_count = '0;
                    link_phase = mlsn_pkg::PHASE_WAIT_TEST1;
                    s.send_kind = mlsn_pkg::SEND_TEST1;
                end
                else if (link_phase == mlsn_pkg::PHASE_WAIT_TEST1 &&
                         c.kind == mlsn_pkg::MSG_TEST1_RESULT)
                begin
                    link_index = second_pick;
                    tick_count = '0;
                    link_phase = mlsn_pkg::PHASE_WAIT_TEST2;
                    s.send_kind = mlsn_pkg::SEND_TEST2;
                end
                else if (link_phase == mlsn_pkg::PHASE_WAIT_TEST2 &&
                         c.kind == mlsn_pkg::MSG_TEST2_RESULT)
                begin
                    tick_count = '0;
                    link_phase = mlsn_pkg::PHASE_OK;
                    s.finished = 1'b1;
                    s.succeeded = 1'b1;
                end
            end
            mlsn_pkg::OP_TICK:
            begin
                if (link_phase >= mlsn_pkg::PHASE_WAIT_ANSW &&
                    link_phase <= mlsn_pkg::PHASE_WAIT_TEST2)
                begin
                    if (tick_count != mlsn_pkg::TICK_MAX)
                    begin
                        tick_count = tick_count + 1'b1;
                    end
                    if (tick_count >= cfg_timeout)
                    begin
                        link_index = '0;
                        link_phase = mlsn_pkg::PHASE_NORMAL;
                        tick_count = '0;
                        s.finished = 1'b1;
                    end
                end
            end
            default:
            begin
                link_index = '0;
                link_phase = mlsn_pkg::PHASE_NORMAL;
                tick_count = '0;
            end
        endcase
        s.chosen_first = first_pick;
        s.chosen_second = second_pick;
        s.active_speed = link_index;
        s.bit_rate = baud_for(link_index);
        s.phase = link_phase;
        predicted_status.push_back(s);
    endtask

    task automatic check_field(input string field, input logic [31:0] want_v,
                               input logic [31:0] got_v);
        if (want_v !== got_v)
        begin
            $display("%0t mismatch %s: expected %0d actual %0d", $time, field, want_v, got_v);
            mismatch_count++;
        end
    endtask

    // input side: hold an offered beat until taken, otherwise offer the next or idle
    always @(negedge clk)
    begin
        if (!in_valid || beat_taken)
        begin
            if (queued_commands.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT))
            begin
                in_valid <= 1'b1;
                op <= queued_commands[0].op;
                msg_kind <= queued_commands[0].kind;
                peer_speeds <= queued_commands[0].peer;
                peer_certified_speeds <= queued_commands[0].peer_cert;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // output side: random stalls plus a long hold-off on request
    always @(negedge clk)
    begin
        if (holds_done < holds_asked)
        begin
            holds_done++;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
        end
    end

    // beat monitor: predict on every taken input beat, compare every taken result beat
    always @(posedge clk)
    begin
        link_status_t want;
        beat_taken = rst_n && in_valid && !in_stall;
        if (beat_taken)
        begin
            advance_negotiation(queued_commands.pop_front());
        end
        if (rst_n && out_valid && !out_stall)
        begin
            if (predicted_status.size() == 0)
            begin
                $display("%0t unexpected result beat: expected none, actual send_kind %0d phase %0d",
                         $time, send_kind, phase);
                mismatch_count++;
            end
            else
            begin
                want = predicted_status.pop_front();
                check_field("send_kind", 32'(want.send_kind), 32'(send_kind));
                check_field("chosen_first", 32'(want.chosen_first), 32'(chosen_first));
                check_field("chosen_second", 32'(want.chosen_second), 32'(chosen_second));
                check_field("active_speed", 32'(want.active_speed), 32'(active_speed));
                check_field("bit_rate", 32'(want.bit_rate), 32'(bit_rate));
                check_field("phase", 32'(want.phase), 32'(phase));
                check_field("finished", 32'(want.finished), 32'(finished));
                check_field("succeeded", 32'(want.succeeded), 32'(succeeded));
            end
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("%0t timeout with %0d beats pending", $time, predicted_status.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic add_beat(input mlsn_pkg::op_t o, input logic [mlsn_pkg::KIND_W-1:0] k,
                            input logic [mlsn_pkg::PEER_W-1:0] p,
                            input logic [mlsn_pkg::PEER_W-1:0] pc);
        link_command_t c;
        c.op = o;
        c.kind = k;
        c.peer = p;
        c.peer_cert = pc;
        queued_commands.push_back(c);
    endtask

    function automatic logic [mlsn_pkg::PEER_W-1:0] any_mask();
        return ($urandom_range(7) == 0) ? '0 : mlsn_pkg::PEER_W'($urandom);
    endfunction

    // a negotiation with random masks, stray ticks and messages, sometimes cut short
    task automatic queue_session();
        logic [mlsn_pkg::KIND_W-1:0] reply [4];
        int unsigned n;
        reply[0] = mlsn_pkg::MSG_SPEED_ANSWER;
        reply[1] = mlsn_pkg::MSG_NEG_ACK;
        reply[2] = mlsn_pkg::MSG_TEST1_RESULT;
        reply[3] = mlsn_pkg::MSG_TEST2_RESULT;
        add_beat(mlsn_pkg::OP_START, mlsn_pkg::KIND_W'($urandom_range(MSG_TOP_CODE)),
                 any_mask(), any_mask());
        for (int s = 0; s < 4; s++)
        begin
            if ($urandom_range(2) == 0)
            begin
                repeat ($urandom_range(1, 4))
                begin
                    add_beat(mlsn_pkg::OP_TICK, mlsn_pkg::KIND_W'($urandom), any_mask(),
                             any_mask());
                end
            end
            n = $urandom_range(99);
            if (n < 8)
            begin
                add_beat(mlsn_pkg::OP_MSG, mlsn_pkg::KIND_W'($urandom_range(MSG_OTHER)),
                         any_mask(), any_mask());
            end
            else if (n < 12)
            begin
                add_beat((n < 10) ? mlsn_pkg::OP_STOP : mlsn_pkg::OP_START,
                         mlsn_pkg::KIND_W'($urandom), any_mask(), any_mask());
                return;
            end
            add_beat(mlsn_pkg::OP_MSG, reply[s], any_mask(), any_mask());
        end
    endtask

    // wait for the block to go quiet
    task automatic drain();
        while (queued_commands.size() != 0 || predicted_status.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    // one configuration access, setup then access phase
    task automatic apb_access(input logic [mlsn_pkg::REG_SEL_W-1:0] sel, input bit wr,
                              input logic [mlsn_pkg::DATA_W-1:0] wdata,
                              output logic [mlsn_pkg::DATA_W-1:0] rdata);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= {sel, 2'b00};
        pwdata <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        rdata = prdata;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic reg_check(input logic [mlsn_pkg::REG_SEL_W-1:0] sel,
                             input logic [mlsn_pkg::DATA_W-1:0] want_v);
        logic [mlsn_pkg::DATA_W-1:0] got;
        apb_access(sel, 1'b0, '0, got);
        check_field("register readback", want_v, got);
    endtask

    task automatic reg_write(input logic [mlsn_pkg::REG_SEL_W-1:0] sel,
                             input logic [mlsn_pkg::DATA_W-1:0] value);
        logic [mlsn_pkg::DATA_W-1:0] unused;
        apb_access(sel, 1'b1, value, unused);
        case (sel)
            mlsn_pkg::REG_LOCAL_SPEEDS:
            begin
                cfg_speeds = value[mlsn_pkg::LOCAL_W-1:0];
                reg_check(sel, mlsn_pkg::DATA_W'(cfg_speeds));
            end
            mlsn_pkg::REG_LOCAL_CERT:
            begin
                cfg_certified = value[mlsn_pkg::LOCAL_W-1:0];
                reg_check(sel, mlsn_pkg::DATA_W'(cfg_certified));
            end
            default:
            begin
                cfg_timeout = value[mlsn_pkg::TICK_W-1:0];
                reg_check(sel, mlsn_pkg::DATA_W'(cfg_timeout));
            end
        endcase
    endtask

    task automatic set_registers(input logic [mlsn_pkg::LOCAL_W-1:0] speeds,
                                 input logic [mlsn_pkg::LOCAL_W-1:0] certified,
                                 input logic [mlsn_pkg::TICK_W-1:0] ticks);
        drain();
        reg_write(mlsn_pkg::REG_LOCAL_SPEEDS, mlsn_pkg::DATA_W'(speeds));
        reg_write(mlsn_pkg::REG_LOCAL_CERT, mlsn_pkg::DATA_W'(certified));
        reg_write(mlsn_pkg::REG_TIMEOUT, mlsn_pkg::DATA_W'(ticks));
    endtask

    // stimulus sequence
    initial
    begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // registers after reset
        reg_check(mlsn_pkg::REG_LOCAL_SPEEDS, '0);
        reg_check(mlsn_pkg::REG_LOCAL_CERT, '0);
        reg_check(mlsn_pkg::REG_TIMEOUT, mlsn_pkg::DATA_W'(mlsn_pkg::TIMEOUT_RESET));

        // directed: ignored items, full success at the top speed, restarts, timeout, stop
        set_registers(11'h7FF, 11'h7FF, 16'd3);
        add_beat(mlsn_pkg::OP_STOP, mlsn_pkg::MSG_SPEED_ANSWER, 14'h3FFF, 14'h0000);
        add_beat(mlsn_pkg::OP_TICK, mlsn_pkg::MSG_SPEED_ANSWER, 14'h0000, 14'h3FFF);
        add_beat(mlsn_pkg::OP_MSG, mlsn_pkg::MSG_SPEED_ANSWER, 14'h3FFF, 14'h3FFF);
        add_beat(mlsn_pkg::OP_START, MSG_TOP_CODE, 14'h3FFF, 14'h3FFF);
        add_beat(mlsn_pkg::OP_MSG, MSG_TOP_CODE, 14'h3FFF, 14'h3FFF);
        add_beat(mlsn_pkg::OP_MSG, MSG_OTHER, 14'h3FFF, 14'h3FFF);
        add_beat(mlsn_pkg::OP_MSG, mlsn_pkg::MSG_NEG_ACK, 14'h0000, 14'h0000);
        add_beat(mlsn_pkg::OP_MSG, mlsn_pkg::MSG_SPEED_ANSWER, 14'h3FFF, 14'h3FFF);
        add_beat(mlsn_pkg::OP_MSG, mlsn_pkg::MSG_NEG_ACK, 14'h0000, 14'h0000);
        add_beat(mlsn_pkg::OP_MSG, mlsn_pkg::MSG_TEST1_RESULT, 14'h0000, 14'h0000);
        add_beat(mlsn_pkg::OP_MSG, mlsn_pkg::MSG_TEST2_RESULT, 14'h0000, 14'h0000);
        add_beat(mlsn_pkg::OP_TICK, mlsn_pkg::MSG_SPEED_ANSWER, 14'h0000, 14'h0000);
        add_beat(mlsn_pkg::OP_START, mlsn_pkg::MSG_SPEED_ANSWER, 14'h0000, 14'h0000);
        add_beat(mlsn_pkg::OP_MSG, mlsn_pkg::MSG_SPEED_ANSWER, 14'h0000, 14'h0000);
        add_beat(mlsn_pkg::OP_START, mlsn_pkg::MSG_SPEED_ANSWER, 14'h0000, 14'h0000);
        add_beat(mlsn_pkg::OP_MSG, mlsn_pkg::MSG_SPEED_ANSWER, 14'h0001, 14'h0002);
        repeat (3)
        begin
            add_beat(mlsn_pkg::OP_TICK, mlsn_pkg::MSG_NEG_ACK, 14'h0000, 14'h0000);
        end
        add_beat(mlsn_pkg::OP_START, mlsn_pkg::MSG_SPEED_ANSWER, 14'h0000, 14'h0000);
        add_beat(mlsn_pkg::OP_MSG, mlsn_pkg::MSG_SPEED_ANSWER, 14'h2AAA, 14'h1555);
        add_beat(mlsn_pkg::OP_MSG, mlsn_pkg::MSG_NEG_ACK, 14'h1555, 14'h2AAA);
        add_beat(mlsn_pkg::OP_MSG, mlsn_pkg::MSG_TEST1_RESULT, 14'h0000, 14'h0000);
        add_beat(mlsn_pkg::OP_STOP, mlsn_pkg::MSG_TEST2_RESULT, 14'h0000, 14'h0000);
        add_beat(mlsn_pkg::OP_TICK, mlsn_pkg::MSG_SPEED_ANSWER, 14'h0000, 14'h0000);

        // zero timeout fails on the first tick
        set_registers(11'h7FF, 11'h7FF, 16'd0);
        add_beat(mlsn_pkg::OP_START, mlsn_pkg::MSG_SPEED_ANSWER, 14'h0000, 14'h0000);
        add_beat(mlsn_pkg::OP_TICK, mlsn_pkg::MSG_SPEED_ANSWER, 14'h0000, 14'h0000);

        // random sessions under several settings
        set_registers(mlsn_pkg::LOCAL_W'($urandom), mlsn_pkg::LOCAL_W'($urandom),
                      mlsn_pkg::TICK_W'($urandom_range(2, 6)));
        repeat (SESSIONS) queue_session();

        set_registers(11'h7FF, 11'h000, 16'd1);
        repeat (SESSIONS) queue_session();

        set_registers(11'h000, 11'h7FF, 16'hFFFF);
        steady = 1'b1;
        repeat (SESSIONS) queue_session();
        drain();
        steady = 1'b0;

        // long receiver hold-off fills the block while beats keep coming
        set_registers(mlsn_pkg::LOCAL_W'($urandom), mlsn_pkg::LOCAL_W'($urandom),
                      mlsn_pkg::TICK_W'($urandom_range(3, 8)));
        repeat (SESSIONS) queue_session();
        holds_asked++;

        drain();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

`default_nettype wire
